[rtl/rrs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared types and constants for the round-robin time-slice scheduler.
// ----------------------------------------------------------------------------
package rrs_pkg;

  localparam int ID_W       = 4;
  localparam int SVC_W      = 10;
  localparam int QUANTUM_W  = 8;
  localparam int OUT_TIME_W = 16;
  localparam int ID_SLOTS   = 2 ** ID_W;

  localparam logic KIND_ARRIVAL = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [ID_W-1:0]  process_id;
    logic [SVC_W-1:0] svc_len;
  } rrs_in_t;

  typedef struct packed {
    logic                  ran;
    logic [ID_W-1:0]       running_id;
    logic                  finished;
    logic [OUT_TIME_W-1:0] finish_time;
    logic [OUT_TIME_W-1:0] turnaround;
    logic                  overflow;
  } rrs_out_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [SVC_W-1:0] rem;
  } rrs_entry_t;

  typedef logic [QUANTUM_W-1:0] rrs_cfg_t;

endpackage
`default_nettype wire

[rtl/rrs_chan_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrs_chan_if
// Valid/ready channel carrying one request of payload type T.
// ----------------------------------------------------------------------------
interface rrs_chan_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface
`default_nettype wire

[rtl/round_robin_scheduler.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_scheduler
// Round-robin time-slice scheduler: arrivals enqueue process requests, ticks
// serve the queue head for one time unit with quantum preemption.
// Latency: ticks and dropped arrivals give a result in the cycle after acceptance.
// Throughput: one request per cycle; the only stall is a held, untaken result.
// The queue head sits in a register, the rest of the queue in a memory with a
// registered read of the next head, so each request is one short pass.
// Reset (synchronous, rst_n low): queue empty, time 0, quantum 1, no result.
// ----------------------------------------------------------------------------
module round_robin_scheduler
  import rrs_pkg::*;
#(
  parameter int MAX_PROCS = 16,
  parameter int TIME_BITS = 16
) (
  input  wire               clk,
  input  wire               rst_n,
  rrs_chan_if.sink          in_ch,
  rrs_chan_if.source        out_ch,
  rrs_chan_if.sink          cfg_ch
);

  localparam int IDX_W = $clog2(MAX_PROCS);
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam logic [CNT_W:0]     MAX_CNT = (CNT_W + 1)'(MAX_PROCS);
  localparam logic [IDX_W:0]     DEPTH   = (IDX_W + 1)'(MAX_PROCS);
  localparam logic [IDX_W-1:0]   LAST    = IDX_W'(MAX_PROCS - 1);

  function automatic logic [QUANTUM_W-1:0] slice_reload(input logic [QUANTUM_W-1:0] q);
    return (q == '0) ? QUANTUM_W'(1) : q;
  endfunction

  // state
  logic [QUANTUM_W-1:0] quantum_r,   quantum_nxt;
  logic [QUANTUM_W-1:0] slice_r,     slice_nxt;
  logic [TIME_BITS-1:0] now_r,       now_nxt;
  logic                 front_vld_r, front_vld_nxt;
  rrs_entry_t           front_r,     front_nxt;
  logic                 held_vld_r,  held_vld_nxt;
  rrs_entry_t           held_r,      held_nxt;
  logic [IDX_W-1:0]     mhead_r,     mhead_nxt;
  logic [CNT_W-1:0]     mcount_r,    mcount_nxt;
  rrs_entry_t           mem_rd_r;
  logic                 out_vld_r,   out_vld_nxt;
  rrs_out_t             out_data_r,  out_data_nxt;

  rrs_entry_t           queue_mem [MAX_PROCS];
  logic [TIME_BITS-1:0] stamp_r   [ID_SLOTS];

  // combinational
  logic                 in_fire;
  logic                 cfg_fire;
  logic                 is_tick;
  logic [SVC_W-1:0]     svc_eff;
  logic [CNT_W:0]       total;
  logic                 full;
  logic [IDX_W:0]       tail_sum;
  logic [IDX_W-1:0]     tail;
  logic [IDX_W-1:0]     head_inc;
  logic                 cur_vld;
  rrs_entry_t           cur;
  logic                 push_mem;
  logic                 pop;
  logic [TIME_BITS-1:0] end_time;
  logic [TIME_BITS-1:0] turn_time;
  logic [TIME_BITS+OUT_TIME_W-1:0] end_ext;
  logic [TIME_BITS+OUT_TIME_W-1:0] turn_ext;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  rrs_entry_t           wr_data;
  logic                 stamp_we;
  logic                 res_vld;
  rrs_out_t             res;

  assign in_ch.ready  = !out_vld_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_data_r;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
  assign is_tick  = (in_ch.data.kind == KIND_TICK);
  assign svc_eff  = (in_ch.data.svc_len == '0) ? SVC_W'(1) : in_ch.data.svc_len;

  assign total = (CNT_W + 1)'(mcount_r) + (CNT_W + 1)'(front_vld_r)
               + (CNT_W + 1)'(held_vld_r);
  assign full  = (total >= MAX_CNT);

  assign tail_sum = {1'b0, mhead_r} + (IDX_W + 1)'(mcount_r);
  assign tail     = (tail_sum >= DEPTH) ? IDX_W'(tail_sum - DEPTH) : tail_sum[IDX_W-1:0];
  assign head_inc = (mhead_r == LAST) ? '0 : mhead_r + IDX_W'(1);

  assign cur_vld  = front_vld_r || held_vld_r;
  assign cur      = front_vld_r ? front_r : held_r;
  assign push_mem = held_vld_r && front_vld_r;

  assign end_time  = now_r + TIME_BITS'(1);
  assign turn_time = end_time - stamp_r[cur.id];
  assign end_ext   = {{OUT_TIME_W{1'b0}}, end_time};
  assign turn_ext  = {{OUT_TIME_W{1'b0}}, turn_time};

  always_comb begin
    quantum_nxt   = quantum_r;
    slice_nxt     = slice_r;
    now_nxt       = now_r;
    front_vld_nxt = front_vld_r;
    front_nxt     = front_r;
    held_vld_nxt  = held_vld_r;
    held_nxt      = held_r;
    mhead_nxt     = mhead_r;
    mcount_nxt    = mcount_r;
    wr_en         = 1'b0;
    wr_addr       = tail;
    wr_data       = held_r;
    stamp_we      = 1'b0;
    pop           = 1'b0;
    res_vld       = 1'b0;
    res           = '0;

    if (in_fire && !is_tick) begin
      if (full) begin
        res_vld      = 1'b1;
        res.overflow = 1'b1;
      end else begin
        stamp_we = 1'b1;
        if (!front_vld_r) begin
          front_vld_nxt = 1'b1;
          front_nxt     = '{id: in_ch.data.process_id, rem: svc_eff};
        end else begin
          wr_en      = 1'b1;
          wr_data    = '{id: in_ch.data.process_id, rem: svc_eff};
          mcount_nxt = mcount_r + CNT_W'(1);
        end
      end
    end else if (in_fire) begin
      res_vld      = 1'b1;
      now_nxt      = end_time;
      held_vld_nxt = 1'b0;
      if (cur_vld) begin
        res.ran        = 1'b1;
        res.running_id = cur.id;
        if (cur.rem <= SVC_W'(1)) begin
          res.finished    = 1'b1;
          res.finish_time = end_ext[OUT_TIME_W-1:0];
          res.turnaround  = turn_ext[OUT_TIME_W-1:0];
          pop             = 1'b1;
          slice_nxt       = slice_reload(quantum_r);
        end else if (slice_r <= QUANTUM_W'(1)) begin
          pop          = 1'b1;
          held_vld_nxt = 1'b1;
          held_nxt     = '{id: cur.id, rem: cur.rem - SVC_W'(1)};
          slice_nxt    = slice_reload(quantum_r);
        end else begin
          slice_nxt     = slice_r - QUANTUM_W'(1);
          front_vld_nxt = 1'b1;
          front_nxt     = '{id: cur.id, rem: cur.rem - SVC_W'(1)};
        end
      end
      if (pop) begin
        if (mcount_r != '0) begin
          front_vld_nxt = 1'b1;
          front_nxt     = mem_rd_r;
          mhead_nxt     = head_inc;
          if (push_mem) begin
            wr_en = 1'b1;
          end else begin
            mcount_nxt = mcount_r - CNT_W'(1);
          end
        end else if (push_mem) begin
          front_vld_nxt = 1'b1;
          front_nxt     = held_r;
        end else begin
          front_vld_nxt = 1'b0;
        end
      end else if (push_mem) begin
        wr_en      = 1'b1;
        mcount_nxt = mcount_r + CNT_W'(1);
      end
    end

    if (cfg_fire) begin
      quantum_nxt = cfg_ch.data;
      slice_nxt   = slice_reload(cfg_ch.data);
    end

    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    if (!out_vld_r || out_ch.ready) begin
      out_vld_nxt  = res_vld;
      out_data_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r   <= QUANTUM_W'(1);
      slice_r     <= QUANTUM_W'(1);
      now_r       <= '0;
      front_vld_r <= 1'b0;
      held_vld_r  <= 1'b0;
      mhead_r     <= '0;
      mcount_r    <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      quantum_r   <= quantum_nxt;
      slice_r     <= slice_nxt;
      now_r       <= now_nxt;
      front_vld_r <= front_vld_nxt;
      held_vld_r  <= held_vld_nxt;
      mhead_r     <= mhead_nxt;
      mcount_r    <= mcount_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_r    <= front_nxt;
    held_r     <= held_nxt;
    out_data_r <= out_data_nxt;
  end

  // queue memory: one write at the tail, registered read of the next head
  always_ff @(posedge clk) begin
    if (wr_en) begin
      queue_mem[wr_addr] <= wr_data;
    end
    if (wr_en && (wr_addr == mhead_nxt)) begin
      mem_rd_r <= wr_data;
    end else begin
      mem_rd_r <= queue_mem[mhead_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (stamp_we) begin
      stamp_r[in_ch.data.process_id] <= now_r;
    end
  end

endmodule
`default_nettype wire

[test/tb_round_robin_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_round_robin_scheduler
// Self-checking bench for the round-robin time-slice scheduler. A clocked
// driver feeds arrival and tick requests from a queue. A scheduling model
// mirrors the ready ring, held process, slice and time counter, and predicts
// the report of every tick and dropped arrival. The monitor compares each
// report field by field. The quantum changes between phases. Both sides stall
// in random bursts, and one long output hold-off backs the block up. One phase
// runs with a long quantum and no idling.
// ----------------------------------------------------------------------------
module tb_round_robin_scheduler;
  import rrs_pkg::*;

  localparam int MAX_PROCS   = 16;
  localparam int TIME_BITS   = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  rrs_chan_if #(.T(rrs_in_t))  in_if ();
  rrs_chan_if #(.T(rrs_out_t)) out_if ();
  rrs_chan_if #(.T(rrs_cfg_t)) cfg_if ();

  round_robin_scheduler u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // scheduling model state
  rrs_cfg_t             quantum    = 8'd1;
  rrs_cfg_t             slice_left = 8'd1;
  rrs_entry_t           ready_ring [MAX_PROCS];
  int unsigned          ring_head  = 0;
  int unsigned          ring_count = 0;
  logic [TIME_BITS-1:0] stamp_of   [ID_SLOTS];
  logic [TIME_BITS-1:0] sched_now  = '0;
  logic                 held_valid = 1'b0;
  rrs_entry_t           held_entry = '0;

  rrs_in_t  request_q [$];
  rrs_out_t due_reports [$];

  int   fault_count = 0;
  int   cycle_count = 0;
  logic in_taken    = 1'b0;
  logic calm        = 1'b0;
  logic hold_req    = 1'b0;
  logic hold_off    = 1'b0;
  int   source_gap  = 0;
  int   sink_stall  = 0;

  function automatic rrs_cfg_t slice_reload();
    return (quantum == '0) ? rrs_cfg_t'(1) : quantum;
  endfunction

  task automatic ring_push(input rrs_entry_t e);
    ready_ring[(ring_head + ring_count) % MAX_PROCS] = e;
    ring_count++;
  endtask

  task automatic ring_pop();
    ring_head = (ring_head + 1) % MAX_PROCS;
    ring_count--;
  endtask

  task automatic advance_schedule(input rrs_in_t req);
    rrs_out_t             rep;
    rrs_entry_t           head;
    logic [SVC_W-1:0]     svc;
    logic [TIME_BITS-1:0] tick_end;
    rep = '0;
    if (req.kind == KIND_ARRIVAL) begin
      svc = (req.svc_len == '0) ? SVC_W'(1) : req.svc_len;
      if (ring_count + held_valid >= MAX_PROCS) begin
        rep.overflow = 1'b1;
        due_reports.insert(due_reports.size(), rep);
      end else begin
        stamp_of[req.process_id] = sched_now;
        ring_push('{id: req.process_id, rem: svc});
      end
    end else begin
      if (held_valid) begin
        ring_push(held_entry);
        held_valid = 1'b0;
      end
      tick_end = sched_now + 1'b1;
      if (ring_count != 0) begin
        head = ready_ring[ring_head];
        rep.ran = 1'b1;
        rep.running_id = head.id;
        if (head.rem <= 1) begin
          rep.finished    = 1'b1;
          rep.finish_time = OUT_TIME_W'(tick_end);
          rep.turnaround  = OUT_TIME_W'(tick_end - stamp_of[head.id]);
          ring_pop();
          slice_left = slice_reload();
        end else begin
          head.rem = head.rem - 1'b1;
          if (slice_left <= 1) begin
            ring_pop();
            held_entry = head;
            held_valid = 1'b1;
            slice_left = slice_reload();
          end else begin
            slice_left = slice_left - 1'b1;
            ready_ring[ring_head] = head;
          end
        end
      end
      sched_now = tick_end;
      due_reports.insert(due_reports.size(), rep);
    end
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      fault_count++;
      if (fault_count <= 10)
        $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    end
  endtask

  task automatic check_report(input rrs_out_t got);
    rrs_out_t want;
    if (due_reports.size() == 0) begin
      fault_count++;
      if (fault_count <= 10)
        $display("report %h arrived with none pending", got);
    end else begin
      want = due_reports.pop_front();
      check_field("ran", want.ran, got.ran);
      check_field("running_id", want.running_id, got.running_id);
      check_field("finished", want.finished, got.finished);
      check_field("finish_time", want.finish_time, got.finish_time);
      check_field("turnaround", want.turnaround, got.turnaround);
      check_field("overflow", want.overflow, got.overflow);
    end
  endtask

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_if.valid && in_if.ready;
      if (out_if.valid && out_if.ready) check_report(out_if.data);
      if (cfg_if.valid && cfg_if.ready) begin
        quantum    = cfg_if.data;
        slice_left = slice_reload();
      end
      if (in_if.valid && in_if.ready) advance_schedule(in_if.data);
    end
  end

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (source_gap > 0) begin
        source_gap--;
        in_if.valid <= 1'b0;
      end else if (request_q.size() > 0 && !calm && $urandom_range(0, 7) == 0) begin
        source_gap = $urandom_range(0, 9);
        in_if.valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        in_if.data  <= request_q.pop_front();
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // report sink
  always @(negedge clk) begin
    if (!rst_n || hold_off) begin
      out_if.ready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      out_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      sink_stall = $urandom_range(0, 9);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always begin
    wait (hold_req);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
    hold_req = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic add_arrival(input int id, input int svc);
    rrs_in_t r;
    r.kind         = KIND_ARRIVAL;
    r.process_id   = ID_W'(id);
    r.svc_len      = SVC_W'(svc);
    request_q.insert(request_q.size(), r);
  endtask

  task automatic add_tick();
    rrs_in_t r;
    r.kind         = KIND_TICK;
    r.process_id   = ID_W'($urandom_range(0, ID_SLOTS - 1));
    r.svc_len      = SVC_W'($urandom_range(0, 1023));
    request_q.insert(request_q.size(), r);
  endtask

  function automatic int pick_service();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 64);
    return $urandom_range(0, 1023);
  endfunction

  task automatic fill_random(input int n);
    int made;
    int k;
    int m;
    made = 0;
    while (made < n) begin
      case ($urandom_range(0, 9))
        6: begin
          k = $urandom_range(17, 20);
          m = $urandom_range(5, 20);
          repeat (k) add_arrival($urandom_range(0, 15), pick_service());
          repeat (m) add_tick();
        end
        7: begin
          k = $urandom_range(1, 10);
          m = 0;
          repeat (k) begin
            if ($urandom_range(0, 1)) add_tick();
            else add_arrival($urandom_range(0, 15), $urandom_range(0, 1023));
          end
        end
        8: begin
          k = 0;
          m = $urandom_range(20, 60);
          repeat (m) add_tick();
        end
        9: begin
          k = $urandom_range(2, 6);
          m = k;
          repeat (k) begin
            add_arrival($urandom_range(0, 15),
                        $urandom_range(0, 1) ? 0 : $urandom_range(0, 1023));
            add_tick();
          end
        end
        default: begin
          k = $urandom_range(1, 5);
          m = $urandom_range(1, 25);
          repeat (k) add_arrival($urandom_range(0, 15), pick_service());
          repeat (m) add_tick();
        end
      endcase
      made += k + m;
    end
  endtask

  // wait until every request is taken and every report is in
  task automatic settle();
    do @(negedge clk);
    while (request_q.size() != 0 || (in_if.valid && !in_taken) ||
           due_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_quantum(input rrs_cfg_t q);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= q;
    do @(posedge clk);
    while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    add_arrival(3, 0);
    add_arrival(15, 1023);
    add_arrival(0, 1);
    add_arrival(3, 2);
    add_arrival(10, 512);
    add_arrival(7, 5);
    repeat (10) add_tick();
    add_arrival(9, 341);
    add_arrival(6, 682);
    repeat (5) add_tick();
    settle();

    // long quantum, no idling
    write_quantum(8'd255);
    calm = 1'b1;
    add_arrival(2, 20);
    add_arrival(12, 3);
    for (int i = 0; i < 40; i++) begin
      add_tick();
      if (i % 8 == 0) add_arrival(i % 16, 2);
    end
    settle();
    calm = 1'b0;

    write_quantum(8'd3);
    fill_random(200);
    settle();
    write_quantum(8'd0);
    fill_random(200);
    settle();
    write_quantum(8'd2);
    fill_random(200);
    hold_req = 1'b1;
    settle();
    write_quantum(8'd1);
    fill_random(200);
    settle();
    write_quantum(rrs_cfg_t'($urandom_range(4, 254)));
    fill_random(200);
    settle();
    write_quantum(8'd7);
    calm = 1'b1;
    fill_random(200);
    settle();

    if (fault_count == 0 && due_reports.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[round_robin_scheduler.f]
rtl/rrs_pkg.sv
rtl/rrs_chan_if.sv
rtl/round_robin_scheduler.sv
test/tb_round_robin_scheduler.sv
